/* rtl/prt_pkg.sv */
`default_nettype none

package prt_pkg;

  // Register map, index = paddr[3:2]
  localparam int unsigned RegAddrW = 4;
  localparam logic [1:0] REG_TIMER_ENABLE = 2'd0;
  localparam logic [1:0] REG_CLOCK_SELECT = 2'd1;
  localparam logic [1:0] REG_RELOAD_VALUE = 2'd2;

  // Clock select codes
  localparam logic [1:0] SEL_1024 = 2'd0;
  localparam logic [1:0] SEL_16   = 2'd1;
  localparam logic [1:0] SEL_64   = 2'd2;
  localparam logic [1:0] SEL_256  = 2'd3;

  localparam int unsigned AccumW = 11;

  // Configuration as seen by the engine
  typedef struct packed {
    logic       timer_enable;
    logic [1:0] clock_select;
    logic [7:0] reload_value;
  } cfg_t;

  // Cycles per counter step for a clock select code
  function automatic logic [AccumW-1:0] period_of(input logic [1:0] sel);
    logic [AccumW-1:0] p;
    case (sel)
      SEL_1024: p = 11'd1024;
      SEL_16:   p = 11'd16;
      SEL_64:   p = 11'd64;
      SEL_256:  p = 11'd256;
      default:  p = 11'd1024;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

/* rtl/prt_regs.sv */
`default_nettype none

module prt_regs
  import prt_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [RegAddrW-1:0] paddr,
  input  wire logic [31:0]         pwdata,
  output logic      [31:0]         prdata,
  output logic                     pready,
  output cfg_t                     cfg_o
);

  cfg_t cfg_q, cfg_d;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // Register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (paddr[3:2])
        REG_TIMER_ENABLE: cfg_d.timer_enable = pwdata[0];
        REG_CLOCK_SELECT: cfg_d.clock_select = pwdata[1:0];
        REG_RELOAD_VALUE: cfg_d.reload_value = pwdata[7:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read mux
  always_comb begin
    case (paddr[3:2])
      REG_TIMER_ENABLE: prdata = {31'd0, cfg_q.timer_enable};
      REG_CLOCK_SELECT: prdata = {30'd0, cfg_q.clock_select};
      REG_RELOAD_VALUE: prdata = {24'd0, cfg_q.reload_value};
      default:          prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

/* rtl/prt_engine.sv */
`default_nettype none

module prt_engine
  import prt_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire cfg_t       cfg_i,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] tick_cycles_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic      [7:0] divider_value_o,
  output logic      [7:0] counter_value_o,
  output logic            timer_irq_o
);

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_DRAIN = 2'b10
  } state_e;

  state_e state_q, state_d;

  logic [7:0]        prescale_q, prescale_d;
  logic [7:0]        divider_q, divider_d;
  logic [AccumW-1:0] accum_q, accum_d;
  logic [7:0]        counter_q, counter_d;
  logic              irq_q, irq_d;

  logic       out_valid_q, out_valid_d;
  logic [7:0] out_div_q, out_div_d;
  logic [7:0] out_cnt_q, out_cnt_d;
  logic       out_irq_q, out_irq_d;

  logic [8:0]        div_sum;
  logic [AccumW:0]   drain_diff;
  logic              drain_ok;
  logic              out_free;

  // Shared subtract/compare: one period out of the accumulator per cycle
  assign drain_diff = {1'b0, accum_q} - {1'b0, period_of(cfg_i.clock_select)};
  assign drain_ok   = cfg_i.timer_enable && !drain_diff[AccumW];

  assign div_sum  = {1'b0, prescale_q} + {1'b0, tick_cycles_i};
  assign out_free = !out_valid_q || out_ready_i;

  assign in_ready_o = (state_q == ST_IDLE);

  // Sequencer
  always_comb begin
    state_d     = state_q;
    prescale_d  = prescale_q;
    divider_d   = divider_q;
    accum_d     = accum_q;
    counter_d   = counter_q;
    irq_d       = irq_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_div_d   = out_div_q;
    out_cnt_d   = out_cnt_q;
    out_irq_d   = out_irq_q;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          prescale_d = div_sum[7:0];
          if (div_sum[8]) begin
            divider_d = divider_q + 8'd1;
          end
          if (cfg_i.timer_enable) begin
            accum_d = accum_q + {3'd0, tick_cycles_i};
          end
          irq_d   = 1'b0;
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (drain_ok) begin
          accum_d = drain_diff[AccumW-1:0];
          if (counter_q == 8'hFF) begin
            counter_d = cfg_i.reload_value;
            irq_d     = 1'b1;
          end else begin
            counter_d = counter_q + 8'd1;
          end
        end else if (out_free) begin
          out_valid_d = 1'b1;
          out_div_d   = divider_q;
          out_cnt_d   = counter_q;
          out_irq_d   = irq_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      prescale_q  <= '0;
      divider_q   <= '0;
      accum_q     <= '0;
      counter_q   <= '0;
      irq_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      prescale_q  <= prescale_d;
      divider_q   <= divider_d;
      accum_q     <= accum_d;
      counter_q   <= counter_d;
      irq_q       <= irq_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result register, no reset needed
  always_ff @(posedge clk_i) begin
    out_div_q <= out_div_d;
    out_cnt_q <= out_cnt_d;
    out_irq_q <= out_irq_d;
  end

  assign out_valid_o     = out_valid_q;
  assign divider_value_o = out_div_q;
  assign counter_value_o = out_cnt_q;
  assign timer_irq_o     = out_irq_q;

endmodule

`default_nettype wire

/* rtl/prescaled_reload_timer_core.sv */
// Channel   Dir  Handshake               Payload
// input     in   in_valid_i/in_ready_o   tick_cycles_i[7:0]
// result    out  out_valid_o/out_ready_i divider_value_o, counter_value_o, timer_irq_o
// config    in   APB psel/penable/pready timer_enable, clock_select, reload_value
//
// An item drains N counter steps, N being up to 16 at period 16 and up to 79
// after a period change; one shared subtractor takes one period out of the
// accumulator per cycle.
// Reset clears timer state and config, not the result data; no clearing pass.
// A finished result waits in an output register, so the next item is taken
// while it is unread; a drained item stalls only if that register is still full.
`default_nettype none

module prescaled_reload_timer_core
  import prt_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [RegAddrW-1:0] paddr,
  input  wire logic [31:0]         pwdata,
  output logic      [31:0]         prdata,
  output logic                     pready,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [7:0]          tick_cycles_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic      [7:0]          divider_value_o,
  output logic      [7:0]          counter_value_o,
  output logic                     timer_irq_o
);

  cfg_t cfg;

  prt_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  prt_engine u_engine (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .tick_cycles_i   (tick_cycles_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .divider_value_o (divider_value_o),
    .counter_value_o (counter_value_o),
    .timer_irq_o     (timer_irq_o)
  );

endmodule

`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import prt_pkg::*;

  localparam int         WatchdogLimit = 3000;
  localparam int         HoldCycles    = 200;
  localparam int         TailCycles    = 90;
  localparam logic [1:0] REG_UNMAPPED  = 2'd3;

  // One result transfer as the timer reports it
  typedef struct packed {
    logic [7:0] divider;
    logic [7:0] counter;
    logic       irq;
  } timer_snapshot_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                psel          = 1'b0;
  logic                penable       = 1'b0;
  logic                pwrite        = 1'b0;
  logic [RegAddrW-1:0] paddr         = '0;
  logic [31:0]         pwdata        = '0;
  logic [31:0]         prdata;
  logic                pready;
  logic                in_valid_i    = 1'b0;
  logic                in_ready_o;
  logic [7:0]          tick_cycles_i = '0;
  logic                out_valid_o;
  logic                out_ready_i   = 1'b0;
  logic [7:0]          divider_value_o;
  logic [7:0]          counter_value_o;
  logic                timer_irq_o;

  // Predicted timer state and register mirror
  logic [7:0]  prescale_cnt = '0;
  logic [7:0]  divider_cnt  = '0;
  logic [10:0] accum_cycles = '0;
  logic [7:0]  timer_cnt    = '0;
  logic        enable_reg   = 1'b0;
  logic [1:0]  select_reg   = SEL_1024;
  logic [7:0]  reload_reg   = '0;

  timer_snapshot_t pending_snapshots[$];
  timer_snapshot_t want_snapshot;

  int error_count   = 0;
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int hold_requests = 0;
  int hold_served   = 0;
  int hold_left     = 0;

  prescaled_reload_timer_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .tick_cycles_i   (tick_cycles_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .divider_value_o (divider_value_o),
    .counter_value_o (counter_value_o),
    .timer_irq_o     (timer_irq_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t mismatch: %s got %0h want %0h", $time, what, got, want);
    error_count++;
  endtask

  // Advance the predicted timer by one tick transfer
  function automatic timer_snapshot_t advance_timer(input logic [7:0] cycles);
    logic [8:0]      sum;
    logic [10:0]     period;
    timer_snapshot_t snap;
    snap.irq = 1'b0;
    sum = {1'b0, prescale_cnt} + {1'b0, cycles};
    if (sum >= 9'd256) begin
      sum         = sum - 9'd256;
      divider_cnt = divider_cnt + 8'd1;
    end
    prescale_cnt = sum[7:0];
    if (enable_reg) begin
      period = 11'd1024;
      case (select_reg)
        SEL_1024: period = 11'd1024;
        SEL_16:   period = 11'd16;
        SEL_64:   period = 11'd64;
        SEL_256:  period = 11'd256;
      endcase
      accum_cycles = accum_cycles + {3'b000, cycles};
      // drain every whole period; may wrap more than once
      while (accum_cycles >= period) begin
        accum_cycles = accum_cycles - period;
        if (timer_cnt == 8'hFF) begin
          timer_cnt = reload_reg;
          snap.irq  = 1'b1;
        end else begin
          timer_cnt = timer_cnt + 8'd1;
        end
      end
    end
    snap.divider = divider_cnt;
    snap.counter = timer_cnt;
    return snap;
  endfunction

  function automatic logic [7:0] pick_ticks();
    int unsigned roll;
    roll = $urandom_range(9);
    if (roll == 0) return 8'h00;
    if (roll == 1) return 8'hFF;
    return 8'($urandom());
  endfunction

  // Result sink: random stalls, plus a counted hold-off on request
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      out_ready_i <= 1'b0;
      hold_left   <= hold_left - 1;
    end else if (hold_served != hold_requests) begin
      out_ready_i <= 1'b0;
      hold_left   <= HoldCycles;
      hold_served <= hold_requests;
    end else begin
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Compare each result transfer with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_snapshots.size() == 0) begin
        report_mismatch("result with nothing pending",
                        {15'd0, divider_value_o, counter_value_o, timer_irq_o}, '0);
      end else begin
        want_snapshot = pending_snapshots.pop_front();
        if (divider_value_o !== want_snapshot.divider)
          report_mismatch("divider_value", {24'd0, divider_value_o},
                          {24'd0, want_snapshot.divider});
        if (counter_value_o !== want_snapshot.counter)
          report_mismatch("counter_value", {24'd0, counter_value_o},
                          {24'd0, want_snapshot.counter});
        if (timer_irq_o !== want_snapshot.irq)
          report_mismatch("timer_irq", {31'd0, timer_irq_o},
                          {31'd0, want_snapshot.irq});
      end
    end
  end

  // Watchdog on cycles without any transfer
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WatchdogLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || psel)
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("watchdog: no transfer for %0d cycles", WatchdogLimit);
    $display("RESULT: ERROR");
    $finish;
  end

  // Offer one tick item and record its prediction once transferred
  task automatic send_tick(input logic [7:0] cycles);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    tick_cycles_i <= cycles;
    do @(posedge clk_i); while (!in_ready_o);
    pending_snapshots.push_back(advance_timer(cycles));
  endtask

  // Stop offering and wait until every prediction is matched
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_snapshots.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [1:0] index, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= RegAddrW'({index, 2'b00});
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (index)
      REG_TIMER_ENABLE: enable_reg = data[0];
      REG_CLOCK_SELECT: select_reg = data[1:0];
      REG_RELOAD_VALUE: reload_reg = data[7:0];
      default: ;
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apb_read(input logic [1:0] index, output logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= RegAddrW'({index, 2'b00});
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    data = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Write all three registers; upper data bits are junk and must be dropped
  task automatic set_timer(input logic enable, input logic [1:0] sel,
                           input logic [7:0] reload);
    apb_write(REG_TIMER_ENABLE, {31'($urandom()), enable});
    apb_write(REG_CLOCK_SELECT, {30'($urandom()), sel});
    apb_write(REG_RELOAD_VALUE, {24'($urandom()), reload});
  endtask

  task automatic check_registers();
    logic [31:0] value;
    apb_read(REG_TIMER_ENABLE, value);
    if (value !== {31'd0, enable_reg})
      report_mismatch("timer_enable readback", value, {31'd0, enable_reg});
    apb_read(REG_CLOCK_SELECT, value);
    if (value !== {30'd0, select_reg})
      report_mismatch("clock_select readback", value, {30'd0, select_reg});
    apb_read(REG_RELOAD_VALUE, value);
    if (value !== {24'd0, reload_reg})
      report_mismatch("reload_value readback", value, {24'd0, reload_reg});
  endtask

  // Reset values; divider runs while the timer is off
  task automatic test_reset_state();
    check_registers();
    send_tick(8'h00);
    send_tick(8'hFF);
    send_tick(8'hFF);
    send_tick(8'h01);
    wait_idle();
  endtask

  // Register writes keep only their low bits; unmapped index is ignored
  task automatic test_register_access();
    set_timer(1'b1, SEL_256, 8'hFF);
    check_registers();
    apb_write(REG_UNMAPPED, $urandom());
    check_registers();
    set_timer(1'b0, SEL_1024, 8'h00);
    check_registers();
  endtask

  // Each period, hold while disabled, and a big drain after a period change
  task automatic test_directed_periods();
    set_timer(1'b1, SEL_1024, 8'hFF);
    repeat (4) send_tick(8'hFF);
    send_tick(8'd3);
    wait_idle();
    // disabled: counter and accumulator hold
    set_timer(1'b0, SEL_1024, 8'hFF);
    send_tick(8'hFF);
    wait_idle();
    // accumulator held at 1023, plus 255, drained at period 16
    set_timer(1'b1, SEL_16, 8'hFF);
    send_tick(8'hFF);
    wait_idle();
    set_timer(1'b1, SEL_64, 8'h00);
    send_tick(8'hFF);
    send_tick(8'h00);
    wait_idle();
    set_timer(1'b1, SEL_256, 8'h80);
    send_tick(8'hFF);
    send_tick(8'h01);
    wait_idle();
  endtask

  // Random ticks under each idling pattern and a rotating configuration
  task automatic test_idle_phases();
    int         choice;
    logic [7:0] reload;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 68; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 68; end
        default: begin send_idle_pct = 27; stall_pct = 27; end
      endcase
      for (int slot = 0; slot < 3; slot++) begin
        choice = phase * 3 + slot;
        case (choice % 3)
          0: reload = 8'h00;
          1: reload = 8'hFF;
          default: reload = 8'($urandom());
        endcase
        set_timer((choice % 5) != 4, 2'(choice % 4), reload);
        repeat (42) send_tick(pick_ticks());
        wait_idle();
      end
    end
  endtask

  // Fast period with reload near the top: overflow on nearly every step
  task automatic test_counter_overflow();
    send_idle_pct = 27;
    stall_pct     = 27;
    set_timer(1'b1, SEL_16, 8'hFF);
    repeat (20) send_tick(8'hFF);
    wait_idle();
    set_timer(1'b1, SEL_16, 8'hFE);
    repeat (20) send_tick(pick_ticks());
    wait_idle();
  endtask

  // Fill the accumulator to 1023 at the slow period, then switch to period 16 so one
  // transfer drains 79 steps and wraps the counter at least twice
  task automatic test_period_switch();
    logic [7:0] reload_hi;
    int         gap;
    send_idle_pct = 27;
    stall_pct     = 27;
    repeat (3) begin
      set_timer(1'b1, SEL_16, 8'h00);
      while (timer_cnt < 8'd200) send_tick(8'hFF);
      wait_idle();
      set_timer(1'b1, SEL_1024, 8'h00);
      while (accum_cycles != 11'd1023) begin
        gap = 1023 - int'(accum_cycles);
        send_tick(gap > 255 ? 8'hFF : 8'(gap));
      end
      wait_idle();
      reload_hi = 8'($urandom_range(255, 240));
      set_timer(1'b1, SEL_16, reload_hi);
      send_tick(8'hFF);
      repeat (8) send_tick(pick_ticks());
      wait_idle();
    end
  endtask

  // Long receiver hold-off fills the block; then a full drain pause
  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_pct     = 0;
    set_timer(1'b1, SEL_16, 8'($urandom()));
    hold_requests = hold_requests + 1;
    repeat (24) send_tick(pick_ticks());
    wait_idle();
    repeat (24) send_tick(pick_ticks());
    wait_idle();
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_state();
    test_register_access();
    test_directed_periods();
    test_idle_phases();
    test_counter_overflow();
    test_period_switch();
    test_backpressure();
    wait_idle();
    repeat (TailCycles) @(posedge clk_i);
    if (error_count == 0 && pending_snapshots.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/prt_pkg.sv
rtl/prt_regs.sv
rtl/prt_engine.sv
rtl/prescaled_reload_timer_core.sv
tb/tb_top.sv
